// ===== rtl/core/plc_pkg.sv =====
package plc_pkg;

	typedef logic signed [31:0] fx_t;

	localparam int FRAC_W     = 16;
	localparam int NUM_W      = 34;
	localparam int DEN_W      = 36;
	localparam int MAX_PASSES = 5;
	localparam int PASS_W     = $clog2(MAX_PASSES + 1);
	localparam int CFG_IDX_W  = 2;

	// outcode bit positions
	localparam int OC_NEAR   = 0;
	localparam int OC_FAR    = 1;
	localparam int OC_TOP    = 2;
	localparam int OC_BOTTOM = 3;
	localparam int OC_RIGHT  = 4;
	localparam int OC_LEFT   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAR     = 2'd2;

	localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
	localparam fx_t FX_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		PL_NEAR,
		PL_FAR,
		PL_TOP,
		PL_BOTTOM,
		PL_RIGHT,
		PL_LEFT
	} plane_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_go;
		logic div_sel;
		logic cap1;
		logic cap2;
		logic mul_go;
		logic add_go;
		logic y_sel;
		logic wb;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic reject;
		logic is_z;
		logic div_done;
	} sts_t;

	function automatic fx_t sat36(logic signed [35:0] v);
		fx_t r;
		if (v > 36'sh0_7FFF_FFFF)
			r = FX_MAX;
		else if (v < -36'sh0_8000_0000)
			r = FX_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/perspective_line_clipper.sv =====
// 3d line clipper against a perspective view volume (near, far, optional
// x=+-|z| and y=+-|z| side planes), 16.16 signed fixed point.
// command channel: a segment beat is taken when start is high and busy low.
// one result per segment: done pulses for exactly one cycle with visible and
// the six clipped coordinates; the receiver must take it then, it cannot stall.
// a trivially accepted or rejected segment is settled in ST_EVAL. each push
// pass runs the shared restoring divider (50 quotient bits, one per cycle)
// once for a side plane and twice for near/far; at most 5 passes.
// one segment at a time; busy stays high until the result strobe.
// config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; index
// 0 side planes enable, 1 near plane, 2 far plane, 3 is ignored. write only
// while idle. reset: side planes on, near 1.0, far max, controller idle.
module perspective_line_clipper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  plc_pkg::fx_t                      start_x,
	input  plc_pkg::fx_t                      start_y,
	input  plc_pkg::fx_t                      start_z,
	input  plc_pkg::fx_t                      end_x,
	input  plc_pkg::fx_t                      end_y,
	input  plc_pkg::fx_t                      end_z,
	output logic                              done,
	output logic                              visible,
	output plc_pkg::fx_t                      clipped_start_x,
	output plc_pkg::fx_t                      clipped_start_y,
	output plc_pkg::fx_t                      clipped_start_z,
	output plc_pkg::fx_t                      clipped_end_x,
	output plc_pkg::fx_t                      clipped_end_y,
	output plc_pkg::fx_t                      clipped_end_z,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  plc_pkg::fx_t                      cfg_data
);
	import plc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	plc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.visible (visible),
		.cmd     (cmd),
		.sts     (sts)
	);

	plc_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.start_x         (start_x),
		.start_y         (start_y),
		.start_z         (start_z),
		.end_x           (end_x),
		.end_y           (end_y),
		.end_z           (end_z),
		.vis             (visible),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_start_z (clipped_start_z),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y),
		.clipped_end_z   (clipped_end_z)
	);

endmodule

// ===== rtl/core/plc_div.sv =====
module plc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [plc_pkg::NUM_W-1:0]  num,
	input  logic signed [plc_pkg::DEN_W-1:0]  den,
	output logic                              done,
	output plc_pkg::fx_t                      quo
);
	import plc_pkg::*;

	localparam int DVD_W = NUM_W + FRAC_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_t;

	dv_state_t          st_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   dmag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic               zero_q;
	logic               nonneg_q;

	logic [NUM_W-1:0]   nmag;
	logic [DEN_W-1:0]   dmag;
	logic [DEN_W:0]     rem_sh;
	logic               ge;

	assign nmag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dmag   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				DV_IDLE: begin
					if (start) begin
						zero_q   <= (den == '0);
						nonneg_q <= !num[NUM_W-1];
						neg_q    <= num[NUM_W-1] ^ den[DEN_W-1];
						dmag_q   <= dmag;
						rem_q    <= '0;
						dvd_q    <= {nmag, {FRAC_W{1'b0}}};
						cnt_q    <= CNT_W'(DVD_W);
						st_q     <= (den == '0) ? DV_FIN : DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q <= ge ? DEN_W'(rem_sh - {1'b0, dmag_q}) : rem_sh[DEN_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						st_q <= DV_FIN;
				end
				DV_FIN: st_q <= DV_IDLE;
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	assign done = (st_q == DV_FIN);

	always_comb begin
		if (zero_q)
			quo = nonneg_q ? FX_MAX : FX_MIN;
		else if (!neg_q)
			quo = (dvd_q > DVD_W'(32'h7FFF_FFFF)) ? FX_MAX : fx_t'(dvd_q[31:0]);
		else
			quo = (dvd_q > DVD_W'(33'h0_8000_0000)) ? FX_MIN : fx_t'(-dvd_q[31:0]);
	end

	assert property (@(posedge clk) disable iff (!arst_n) (st_q == DV_RUN) |-> (cnt_q != '0))
		else $error("divider running with zero count");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("divider done held");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && st_q == DV_IDLE && den == '0) |=> done)
		else $error("zero divisor not short-cut");

endmodule

// ===== rtl/core/plc_dpath.sv =====
module plc_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  plc_pkg::cmd_t                     cmd,
	output plc_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  plc_pkg::fx_t                      cfg_data,
	input  plc_pkg::fx_t                      start_x,
	input  plc_pkg::fx_t                      start_y,
	input  plc_pkg::fx_t                      start_z,
	input  plc_pkg::fx_t                      end_x,
	input  plc_pkg::fx_t                      end_y,
	input  plc_pkg::fx_t                      end_z,
	input  logic                              vis,
	output plc_pkg::fx_t                      clipped_start_x,
	output plc_pkg::fx_t                      clipped_start_y,
	output plc_pkg::fx_t                      clipped_start_z,
	output plc_pkg::fx_t                      clipped_end_x,
	output plc_pkg::fx_t                      clipped_end_y,
	output plc_pkg::fx_t                      clipped_end_z
);
	import plc_pkg::*;

	logic  side_en_q;
	fx_t   near_q, far_q;
	fx_t   sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
	logic  sel_end_q;
	plane_t plane_q;
	fx_t   d1_q, d2_q, rx_q, ry_q;
	logic signed [63:0] prod_q;

	logic [5:0] cs, ce, code;
	fx_t   px, py, pz, qx, qy, qz, plane, h, ma, mb, mres, pbase, newz;
	logic signed [NUM_W-1:0] dnum;
	logic signed [DEN_W-1:0] dden;
	logic  div_done;
	fx_t   quo;
	logic signed [47:0] shq;
	logic signed [35:0] sum;

	function automatic logic [5:0] outcode(fx_t x, fx_t y, fx_t z, logic en, fx_t nr,
		fx_t fr);
		logic signed [33:0] az;
		logic [5:0] c;
		az = z[31] ? -34'(z) : 34'(z);
		c = '0;
		if (en) begin
			c[OC_LEFT]   = 34'(x) < -az;
			c[OC_RIGHT]  = 34'(x) > az;
			c[OC_TOP]    = 34'(y) < -az;
			c[OC_BOTTOM] = 34'(y) > az;
		end
		c[OC_NEAR] = z < nr;
		c[OC_FAR]  = z > fr;
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_en_q <= 1'b1;
			near_q    <= 32'sh0001_0000;
			far_q     <= FX_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_EN: side_en_q <= cfg_data[0];
				REG_NEAR:    near_q    <= cfg_data;
				REG_FAR:     far_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cs = outcode(sx_q, sy_q, sz_q, side_en_q, near_q, far_q);
	assign ce = outcode(ex_q, ey_q, ez_q, side_en_q, near_q, far_q);
	assign code = (cs == '0) ? ce : cs;

	assign sts.accept   = (cs | ce) == '0;
	assign sts.reject   = (cs & ce) != '0;
	assign sts.is_z     = (plane_q == PL_NEAR) || (plane_q == PL_FAR);
	assign sts.div_done = div_done;

	assign px = sel_end_q ? ex_q : sx_q;
	assign py = sel_end_q ? ey_q : sy_q;
	assign pz = sel_end_q ? ez_q : sz_q;
	assign qx = sel_end_q ? sx_q : ex_q;
	assign qy = sel_end_q ? sy_q : ey_q;
	assign qz = sel_end_q ? sz_q : ez_q;

	assign plane = (plane_q == PL_NEAR) ? near_q : far_q;
	assign h     = sat36(36'(plane) - 36'(pz));

	always_comb begin
		dden = DEN_W'(qz) - DEN_W'(pz);
		dnum = cmd.div_sel ? NUM_W'(qx) - NUM_W'(px) : NUM_W'(qy) - NUM_W'(py);
		case (plane_q)
			PL_TOP: begin
				dnum = NUM_W'(pz) + NUM_W'(py);
				dden = (DEN_W'(py) + DEN_W'(pz)) - (DEN_W'(qy) + DEN_W'(qz));
			end
			PL_BOTTOM: begin
				dnum = NUM_W'(pz) - NUM_W'(py);
				dden = (DEN_W'(qy) + DEN_W'(pz)) - (DEN_W'(py) + DEN_W'(qz));
			end
			PL_RIGHT: begin
				dnum = NUM_W'(pz) - NUM_W'(px);
				dden = (DEN_W'(qx) + DEN_W'(pz)) - (DEN_W'(px) + DEN_W'(qz));
			end
			PL_LEFT: begin
				dnum = NUM_W'(pz) + NUM_W'(px);
				dden = (DEN_W'(px) + DEN_W'(pz)) - (DEN_W'(qx) + DEN_W'(qz));
			end
			default: ;
		endcase
	end

	plc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (quo)
	);

	// z planes: slope times height; side planes: delta times k
	always_comb begin
		if (sts.is_z) begin
			ma = cmd.y_sel ? d1_q : d2_q;
			mb = h;
		end else begin
			ma = cmd.y_sel ? sat36(36'(qy) - 36'(py)) : sat36(36'(qx) - 36'(px));
			mb = d1_q;
		end
	end

	// truncate toward zero
	assign shq   = prod_q[63:16] + 48'(prod_q[63] && (prod_q[15:0] != '0));
	assign mres  = (shq > 48'sh7FFF_FFFF) ? FX_MAX : (shq < -48'sh8000_0000) ? FX_MIN :
		shq[31:0];
	assign pbase = cmd.y_sel ? py : px;
	assign sum   = 36'(mres) + 36'(pbase);

	always_comb begin
		case (plane_q)
			PL_NEAR, PL_FAR: newz = plane;
			PL_TOP:          newz = (ry_q == FX_MIN) ? FX_MAX : -ry_q;
			PL_BOTTOM:       newz = ry_q;
			PL_RIGHT:        newz = rx_q;
			default:         newz = (rx_q == FX_MIN) ? FX_MAX : -rx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_end_q <= 1'b0;
			plane_q   <= PL_NEAR;
		end else begin
			if (cmd.setup) begin
				sel_end_q <= (cs == '0);
				if (code[OC_NEAR])        plane_q <= PL_NEAR;
				else if (code[OC_FAR])    plane_q <= PL_FAR;
				else if (code[OC_TOP])    plane_q <= PL_TOP;
				else if (code[OC_BOTTOM]) plane_q <= PL_BOTTOM;
				else if (code[OC_RIGHT])  plane_q <= PL_RIGHT;
				else                      plane_q <= PL_LEFT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= start_x; sy_q <= start_y; sz_q <= start_z;
			ex_q <= end_x;   ey_q <= end_y;   ez_q <= end_z;
		end else if (cmd.wb) begin
			if (sel_end_q) begin
				ex_q <= rx_q; ey_q <= ry_q; ez_q <= newz;
			end else begin
				sx_q <= rx_q; sy_q <= ry_q; sz_q <= newz;
			end
		end
		if (cmd.cap1 && div_done)
			d1_q <= quo;
		if (cmd.cap2 && div_done)
			d2_q <= quo;
		if (cmd.mul_go)
			prod_q <= ma * mb;
		if (cmd.add_go) begin
			if (cmd.y_sel)
				ry_q <= sat36(sum);
			else
				rx_q <= sat36(sum);
		end
	end

	assign clipped_start_x = vis ? sx_q : '0;
	assign clipped_start_y = vis ? sy_q : '0;
	assign clipped_start_z = vis ? sz_q : '0;
	assign clipped_end_x   = vis ? ex_q : '0;
	assign clipped_end_y   = vis ? ey_q : '0;
	assign clipped_end_z   = vis ? ez_q : '0;

	assert property (@(posedge clk) disable iff (!arst_n) cmd.wb |-> !cmd.load)
		else $error("writeback during load");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup |=> (code[OC_NEAR] ? plane_q == PL_NEAR : 1'b1) || $past(cs) != cs)
		else $error("plane priority broken");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_go |-> !div_done)
		else $error("divider restarted while finishing");

endmodule

// ===== rtl/core/plc_ctrl.sv =====
module plc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output logic          visible,
	output plc_pkg::cmd_t cmd,
	input  plc_pkg::sts_t sts
);
	import plc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVAL, ST_SETUP, ST_DIV1, ST_WAIT1, ST_DIV2, ST_WAIT2,
		ST_MULX, ST_ADDX, ST_MULY, ST_ADDY, ST_WB
	} state_t;

	state_t            state_q;
	logic [PASS_W-1:0] pass_q;
	logic              done_q;
	logic              vis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
			done_q  <= 1'b0;
			vis_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						pass_q  <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (sts.accept) begin
						vis_q   <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (sts.reject || pass_q == PASS_W'(MAX_PASSES)) begin
						vis_q   <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_DIV1;
				ST_DIV1:  state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (sts.div_done)
						state_q <= sts.is_z ? ST_DIV2 : ST_MULX;
				end
				ST_DIV2:  state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (sts.div_done)
						state_q <= ST_MULX;
				end
				ST_MULX:  state_q <= ST_ADDX;
				ST_ADDX:  state_q <= ST_MULY;
				ST_MULY:  state_q <= ST_ADDY;
				ST_ADDY:  state_q <= ST_WB;
				ST_WB: begin
					pass_q  <= pass_q + 1'b1;
					state_q <= ST_EVAL;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV1:  cmd.div_go = 1'b1;
			ST_WAIT1: cmd.cap1 = 1'b1;
			ST_DIV2: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = 1'b1;
			end
			ST_WAIT2: cmd.cap2 = 1'b1;
			ST_MULX:  cmd.mul_go = 1'b1;
			ST_ADDX:  cmd.add_go = 1'b1;
			ST_MULY: begin
				cmd.mul_go = 1'b1;
				cmd.y_sel  = 1'b1;
			end
			ST_ADDY: begin
				cmd.add_go = 1'b1;
				cmd.y_sel  = 1'b1;
			end
			ST_WB:    cmd.wb = 1'b1;
			default: ;
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign visible = vis_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n) pass_q <= PASS_W'(MAX_PASSES))
		else $error("pass count overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == ST_IDLE) |=> busy)
		else $error("accepted segment not taken up");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy)
		else $error("result while busy");

endmodule
